// File: sv/fit_policy_partition_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fit-policy partition allocator
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH

// Checked only while out of reset.
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the partition allocator files.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int NUM_PARTS = 8;
  localparam int SIZE_BITS = 16;

  // fixed field widths
  localparam int SEL_W    = 3;
  localparam int AMOUNT_W = 16;
  localparam int CFG_DW   = 4;

  localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTS + 1);

  typedef enum logic [0:0] {
    MODE_LOAD = 1'b0,
    MODE_REQ  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic [0:0] {
    REG_POLICY = 1'b0,
    REG_PARTS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// File: sv/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface fpa_in_if import fpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SEL_W-1:0]    part_select;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, mode, part_select, amount, input ready);
  modport sink   (input valid, mode, part_select, amount, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                placed;
  logic [SEL_W-1:0]    chosen_part;
  logic [AMOUNT_W-1:0] room_left;

  modport source (output valid, placed, chosen_part, room_left, input ready);
  modport sink   (input valid, placed, chosen_part, room_left, output ready);
endinterface

// File: sv/fit_policy_partition_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator
// Partition table with first/best/worst fit search, one entry per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | handshake
//  in_ch    | in  | mode, part_select, amount            | valid/ready
//  out_ch   | out | placed, chosen_part, room_left       | valid/ready
//  cfg_*    | in  | cfg_idx, cfg_wdata                   | cfg_we
//
// A load is written when accepted. A request is accepted, then reads N
// table entries in turn through the single compare unit (N = partitions
// searched, at most 8; first fit stops at the first hit), then writes back.
// Reset is synchronous; there is no clearing pass, the table is undefined.
// A result waiting on out_ch does not block accepting the next request;
// only the write-back stalls until the output register is free.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator import fpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fpa_in_if.sink            in_ch,
  fpa_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [1:0]           policy_r;
  logic [3:0]           parts_r;
  logic [SIZE_BITS-1:0] mem_r [NUM_PARTS];

  logic [SIZE_BITS-1:0] want_r, want_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]     lim_r, lim_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic                 found_r, found_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 placed_r, placed_nxt;
  logic [SEL_W-1:0]     chosen_r, chosen_nxt;
  logic [AMOUNT_W-1:0]  room_r, room_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [SIZE_BITS-1:0] mem_wd;

  logic                 accept;
  logic [SIZE_BITS-1:0] have;
  logic [SIZE_BITS-1:0] room;
  logic                 fits;
  logic                 better;
  logic                 stop_first;
  logic                 last;
  logic [CNT_W-1:0]     lim_calc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.placed      = placed_r;
  assign out_ch.chosen_part = chosen_r;
  assign out_ch.room_left   = room_r;

  // shared compare unit: one table entry per cycle
  assign have = mem_r[scan_r[IDX_W-1:0]];
  assign fits = (have >= want_r);
  assign room = best_r - want_r;
  assign last = (({1'b0, scan_r} + 1'b1) == {1'b0, lim_r});

  always_comb begin
    case (policy_r)
      POL_BEST:  better = (have < best_r);
      POL_WORST: better = (have > best_r);
      default:   better = 1'b0;
    endcase
    stop_first = fits && (policy_r != POL_BEST) && (policy_r != POL_WORST);
  end

  // searched count saturates at the table depth
  assign lim_calc = (32'(parts_r) > NUM_PARTS) ? CNT_W'(NUM_PARTS) : CNT_W'(parts_r);

  always_comb begin
    state_nxt     = state_r;
    want_nxt      = want_r;
    best_nxt      = best_r;
    lim_nxt       = lim_r;
    scan_nxt      = scan_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    placed_nxt    = placed_r;
    chosen_nxt    = chosen_r;
    room_nxt      = room_r;
    mem_we        = 1'b0;
    mem_wa        = IDX_W'(in_ch.part_select);
    mem_wd        = SIZE_BITS'(in_ch.amount);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_LOAD) begin
            mem_we = (32'(in_ch.part_select) < NUM_PARTS);
          end else begin
            want_nxt  = SIZE_BITS'(in_ch.amount);
            lim_nxt   = lim_calc;
            scan_nxt  = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            state_nxt = (lim_calc == '0) ? ST_WRITE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fits && (!found_r || better)) begin
          found_nxt = 1'b1;
          pick_nxt  = scan_r[IDX_W-1:0];
          best_nxt  = have;
        end
        scan_nxt = scan_r + 1'b1;
        if (stop_first || last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          placed_nxt    = found_r;
          chosen_nxt    = found_r ? SEL_W'(pick_r) : '0;
          room_nxt      = found_r ? AMOUNT_W'(room) : '0;
          mem_we        = found_r;
          mem_wa        = pick_r;
          mem_wd        = room;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      policy_r    <= POL_FIRST;
      parts_r     <= 4'(NUM_PARTS);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_POLICY: policy_r <= cfg_wdata[1:0];
          REG_PARTS:  parts_r  <= cfg_wdata[3:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    want_r   <= want_nxt;
    best_r   <= best_nxt;
    lim_r    <= lim_nxt;
    scan_r   <= scan_nxt;
    pick_r   <= pick_nxt;
    found_r  <= found_nxt;
    placed_r <= placed_nxt;
    chosen_r <= chosen_nxt;
    room_r   <= room_nxt;
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
  end

endmodule

// File: sv/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the partition allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fit_policy_partition_allocator_assert.svh"

module fpa_checker import fpa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_mode,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_placed,
  input logic [SEL_W-1:0]    out_chosen_part,
  input logic [AMOUNT_W-1:0] out_room_left
);

  // a stalled result keeps its payload
  `FPA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_placed) && $stable(out_chosen_part) && $stable(out_room_left), "result changed while stalled")

  // unplaced request reports zero index and zero room
  `FPA_ASSERT(a_unplaced_zero, clk, rst_n, out_valid && !out_placed |-> out_chosen_part == '0 && out_room_left == '0, "unplaced result not zeroed")

  // a request occupies the search unit for at least the next cycle
  `FPA_ASSERT(a_req_busy, clk, rst_n, in_valid && in_ready && in_mode == MODE_REQ |=> !in_ready, "ready while a request is being searched")

  // nothing is offered right after reset
  `FPA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_mode         (in_ch.mode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_placed      (out_ch.placed),
  .out_chosen_part (out_ch.chosen_part),
  .out_room_left   (out_ch.room_left)
);

// File: dv/tb_fit_policy_partition_allocator.sv
// ----------------------------------------------------------------------------
// tb_fit_policy_partition_allocator
// Drives load and allocation requests into the partition allocator under
// every fit policy and a range of search depths. A local copy of the
// partition table predicts each result, which is compared in order with
// what the block returns. A short table of directed steps comes first,
// then random segments with varying back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_fit_policy_partition_allocator;
  import fpa_pkg::*;

  localparam int N_SEGS         = 12;
  localparam int SEG_ITEMS      = 125;
  localparam int HOLD_SEG       = 5;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic                placed;
    logic [SEL_W-1:0]    part;
    logic [AMOUNT_W-1:0] room;
  } alloc_res_t;

  typedef enum {RK_LOAD, RK_REQ, RK_POL, RK_PARTS} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CFG_DW-1:0]   arg;     // partition for loads, value for register rows
    logic [AMOUNT_W-1:0] amount;
    bit                  typed;
    alloc_res_t          want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic              cfg_we;
  cfg_reg_t          cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fit_policy_partition_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the block's state and registers
  logic [AMOUNT_W-1:0] part_room [NUM_PARTS];
  logic [1:0]          cur_policy = POL_FIRST;
  logic [CFG_DW-1:0]   cur_parts  = 4'd8;

  alloc_res_t expected_allocs [$];
  int         n_fail        = 0;
  int         src_idle_pct  = 0;
  int         snk_stall_pct = 0;
  bit         hold_out      = 1'b0;
  int         quiet_cycles  = 0;

  // Table reading starts with all eight partitions loaded, so nothing is
  // ever read before being written.
  dir_row_t dir_rows [27] = '{
    '{RK_LOAD,  4'd0,  16'd100,   1'b0, '0},
    '{RK_LOAD,  4'd1,  16'hFFFF,  1'b0, '0},
    '{RK_LOAD,  4'd2,  16'd50,    1'b0, '0},
    '{RK_LOAD,  4'd3,  16'd0,     1'b0, '0},
    '{RK_LOAD,  4'd4,  16'd300,   1'b0, '0},
    '{RK_LOAD,  4'd5,  16'd50,    1'b0, '0},
    '{RK_LOAD,  4'd6,  16'd200,   1'b0, '0},
    '{RK_LOAD,  4'd7,  16'd1000,  1'b0, '0},
    '{RK_REQ,   4'd0,  16'd60,    1'b1, '{1'b1, 3'd0, 16'd40}},
    '{RK_REQ,   4'd0,  16'd0,     1'b1, '{1'b1, 3'd0, 16'd40}},
    '{RK_REQ,   4'd0,  16'hFFFF,  1'b1, '{1'b1, 3'd1, 16'd0}},
    '{RK_REQ,   4'd0,  16'hFFFF,  1'b1, '{1'b0, 3'd0, 16'd0}},
    '{RK_POL,   4'd1,  16'd0,     1'b0, '0},
    '{RK_REQ,   4'd0,  16'd50,    1'b1, '{1'b1, 3'd2, 16'd0}},   // tie, lower index
    '{RK_REQ,   4'd0,  16'd45,    1'b0, '0},
    '{RK_POL,   4'd2,  16'd0,     1'b0, '0},
    '{RK_REQ,   4'd0,  16'd100,   1'b0, '0},
    '{RK_REQ,   4'd0,  16'd200,   1'b0, '0},
    '{RK_POL,   4'd3,  16'd0,     1'b0, '0},                     // unused code
    '{RK_REQ,   4'd0,  16'd30,    1'b0, '0},
    '{RK_PARTS, 4'd0,  16'd0,     1'b0, '0},
    '{RK_REQ,   4'd0,  16'd0,     1'b1, '{1'b0, 3'd0, 16'd0}},   // empty search
    '{RK_PARTS, 4'd15, 16'd0,     1'b0, '0},
    '{RK_REQ,   4'd0,  16'd600,   1'b0, '0},
    '{RK_PARTS, 4'd1,  16'd0,     1'b0, '0},
    '{RK_POL,   4'd1,  16'd0,     1'b0, '0},
    '{RK_REQ,   4'd0,  16'd11,    1'b1, '{1'b0, 3'd0, 16'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Searches the local table under the current policy and takes the
  // request out of the chosen partition.
  function automatic alloc_res_t fit_search(input logic [AMOUNT_W-1:0] want);
    alloc_res_t res;
    int n;
    int pick;
    res  = '0;
    n    = (cur_parts > NUM_PARTS) ? NUM_PARTS : int'(cur_parts);
    pick = -1;
    for (int j = 0; j < n; j++) begin
      if (part_room[j] < want) continue;
      if (pick < 0) begin
        pick = j;
        if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
      end else if (cur_policy == POL_BEST && part_room[j] < part_room[pick]) begin
        pick = j;
      end else if (cur_policy == POL_WORST && part_room[j] > part_room[pick]) begin
        pick = j;
      end
    end
    if (pick >= 0) begin
      part_room[pick] = part_room[pick] - want;
      res.placed = 1'b1;
      res.part   = pick[SEL_W-1:0];
      res.room   = part_room[pick];
    end
    return res;
  endfunction

  task automatic send_item(input mode_t m, input logic [SEL_W-1:0] s,
                           input logic [AMOUNT_W-1:0] a, input bit typed,
                           input alloc_res_t want);
    alloc_res_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.part_select <= s;
    in_ch.amount      <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (m == MODE_LOAD) begin
      part_room[s] = a;
    end else begin
      res = fit_search(a);
      expected_allocs.push_back(typed ? want : res);
    end
  endtask

  // wait out every outstanding request, then let any load finish
  task automatic drain();
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLICY) cur_policy = val[1:0];
    else cur_parts = val;
    @(posedge clk);
  endtask

  // result sink: random stalls, plus one long hold-off counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_allocs.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        e = expected_allocs.pop_front();
        if (out_ch.placed !== e.placed) begin
          $error("placed: expected %0d, got %0d", e.placed, out_ch.placed);
          n_fail++;
        end
        if (out_ch.chosen_part !== e.part) begin
          $error("chosen_part: expected %0d, got %0d", e.part, out_ch.chosen_part);
          n_fail++;
        end
        if (out_ch.room_left !== e.room) begin
          $error("room_left: expected %0d, got %0d", e.room, out_ch.room_left);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    mode_t               m;
    logic [SEL_W-1:0]    s;
    logic [AMOUNT_W-1:0] a;
    logic [CFG_DW-1:0]   parts;
    int                  roll;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.part_select <= '0;
    in_ch.amount      <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_POLICY;
    cfg_wdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RK_LOAD: begin
          send_item(MODE_LOAD, dir_rows[i].arg[SEL_W-1:0], dir_rows[i].amount, 1'b0, '0);
        end
        RK_REQ: begin
          send_item(MODE_REQ, 3'(i), dir_rows[i].amount, dir_rows[i].typed,
                    dir_rows[i].want);
        end
        default: begin
          in_ch.valid <= 1'b0;
          drain();
          write_reg((dir_rows[i].kind == RK_POL) ? REG_POLICY : REG_PARTS, dir_rows[i].arg);
        end
      endcase
    end

    for (int seg = 0; seg < N_SEGS; seg++) begin
      in_ch.valid <= 1'b0;
      drain();
      case (seg % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase
      case (seg)
        0: parts = 4'd8;
        1: parts = 4'd1;
        2: parts = 4'd0;
        3: parts = 4'd15;
        4: parts = 4'd9;
        default: parts = 4'($urandom_range(1, 8));
      endcase
      // upper bits of the policy write are don't-care
      write_reg(REG_POLICY, {2'($urandom_range(0, 3)), 2'((seg + seg / 4) % 4)});
      write_reg(REG_PARTS, parts);
      if (seg == HOLD_SEG) hold_out = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        s    = 3'($urandom_range(0, 7));
        if (roll < 30) begin
          m = MODE_LOAD;
          case ($urandom_range(0, 9))
            0: a = '0;
            1: a = '1;
            2, 3, 4: a = 16'($urandom_range(0, 63));   // small sizes make ties
            default: a = 16'($urandom_range(0, 65535));
          endcase
        end else begin
          m = MODE_REQ;
          case ($urandom_range(0, 19))
            0: a = '0;
            1: a = '1;
            2, 3, 4, 5, 6: a = 16'($urandom_range(0, 63));
            7, 8, 9, 10, 11: a = 16'($urandom_range(0, 4095));
            default: a = 16'($urandom_range(0, 65535));
          endcase
        end
        send_item(m, s, a, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    drain();
    if (n_fail == 0 && expected_allocs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
